@@ hdl/chr_pkg.sv @@
package chr_pkg;

   typedef enum logic [1:0] {
      REQ_ADD    = 2'd0,
      REQ_REMOVE = 2'd1,
      REQ_LOOKUP = 2'd2,
      REQ_NONE   = 2'd3
   } req_code_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2,
      ST_RSVD  = 2'd3
   } status_code_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_SRCH_RD,
      S_SRCH_CMP,
      S_ADD_DEC,
      S_SHIFT_RD,
      S_SHIFT_WR,
      S_REM_RD,
      S_REM_WR,
      S_LK_RD,
      S_LK_CHK,
      S_EMIT,
      S_ACK
   } state_type;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [7:0]  node_id;
      logic [31:0] ring_token;
      logic [3:0]  want_count;
   } req_beat_type;

   typedef struct packed {
      logic [7:0] found_node;
      logic [1:0] status;
      logic       last_result;
   } rsp_beat_type;

endpackage

@@ hdl/consistent_hash_ring.sv @@
// Each add or non-empty lookup first binary-searches the sorted token table. An add then
// overwrites a matching token, reports full, or shifts later entries up to insert; a
// remove compacts out every entry of its node; a lookup walks on from the found slot,
// checks each owner against the seen list and streams one result beat per distinct node.
// Only one request is handled at a time; the next request is taken only once the last
// result beat has left. Reset (synchronous, active high) clears the entry count and
// control state; the table contents are not cleared.
module consistent_hash_ring #(
   parameter int TABLE_DEPTH  = 256,
   parameter int NODE_ID_BITS = 8,
   parameter int MAX_REPLICAS = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  chr_pkg::req_beat_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output chr_pkg::rsp_beat_type rsp_data
);

   localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam int RW = (MAX_REPLICAS > 1) ? $clog2(MAX_REPLICAS) : 1;
   localparam int FW = $clog2(MAX_REPLICAS + 1);

   logic [31:0]           tok_mem [TABLE_DEPTH];
   logic [NODE_ID_BITS-1:0] own_mem [TABLE_DEPTH];
   logic [NODE_ID_BITS-1:0] seen_ff [MAX_REPLICAS];

   chr_pkg::state_type state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] lo_ff, lo_in, hi_ff, hi_in;
   logic [CW-1:0] ptr_ff, ptr_in, wp_ff, wp_in, walk_ff, walk_in;
   logic [FW-1:0] found_ff, found_in, want_ff, want_in, chk_ff, chk_in;
   logic [1:0]    op_ff, op_in;
   logic [NODE_ID_BITS-1:0] node_ff, node_in;
   logic [31:0]   key_ff, key_in, rd_tok_ff;
   logic [NODE_ID_BITS-1:0] rd_own_ff;
   logic          rsp_valid_ff, rsp_valid_in;
   chr_pkg::rsp_beat_type rsp_ff, rsp_in;

   logic          mem_we;
   logic [AW-1:0] mem_wa, mem_ra;
   logic [31:0]   mem_wt;
   logic [NODE_ID_BITS-1:0] mem_wo;
   logic          seen_we;
   logic [CW-1:0] mid;
   logic [CW-1:0] walk_idx;
   logic [CW:0]   walk_sum;
   logic [FW-1:0] want_sat;
   logic          emit_last;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         tok_mem[mem_wa] <= mem_wt;
         own_mem[mem_wa] <= mem_wo;
      end
      rd_tok_ff <= tok_mem[mem_ra];
      rd_own_ff <= own_mem[mem_ra];
      if (seen_we) seen_ff[found_ff[RW-1:0]] <= rd_own_ff;
   end

   assign mid      = lo_ff + ((hi_ff - lo_ff) >> 1);
   assign walk_sum = {1'b0, ptr_ff} + {1'b0, walk_ff};
   assign walk_idx = (walk_sum >= {1'b0, count_ff}) ? CW'(walk_sum - {1'b0, count_ff})
                                                    : walk_sum[CW-1:0];
   assign want_sat = (req_data.want_count == 4'd0 ||
                      32'(req_data.want_count) > MAX_REPLICAS)
                     ? FW'(MAX_REPLICAS) : FW'(req_data.want_count);
   assign emit_last = (FW'(chk_ff + 1'b1) == found_ff);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         chr_pkg::S_IDLE: begin
            if (req_valid && !rsp_valid_ff) begin
               unique case (req_data.req_type)
                  chr_pkg::REQ_ADD:    state_in = chr_pkg::S_SRCH_RD;
                  chr_pkg::REQ_REMOVE: state_in = chr_pkg::S_REM_RD;
                  chr_pkg::REQ_LOOKUP: state_in = (count_ff == '0) ? chr_pkg::S_ACK
                                                                   : chr_pkg::S_SRCH_RD;
                  default:             state_in = chr_pkg::S_IDLE;
               endcase
            end
         end
         chr_pkg::S_SRCH_RD:
            state_in = (lo_ff < hi_ff) ? chr_pkg::S_SRCH_CMP
                     : (op_ff == chr_pkg::REQ_ADD) ? chr_pkg::S_ADD_DEC : chr_pkg::S_LK_RD;
         chr_pkg::S_SRCH_CMP: state_in = chr_pkg::S_SRCH_RD;
         chr_pkg::S_ADD_DEC: begin
            if (lo_ff < count_ff && rd_tok_ff == key_ff) state_in = chr_pkg::S_ACK;
            else if (count_ff >= CW'(TABLE_DEPTH))     state_in = chr_pkg::S_ACK;
            else state_in = (ptr_ff > lo_ff) ? chr_pkg::S_SHIFT_RD : chr_pkg::S_SHIFT_WR;
         end
         chr_pkg::S_SHIFT_RD: state_in = chr_pkg::S_SHIFT_WR;
         chr_pkg::S_SHIFT_WR:
            state_in = (ptr_ff > lo_ff) ? chr_pkg::S_SHIFT_RD : chr_pkg::S_ACK;
         chr_pkg::S_REM_RD:
            state_in = (ptr_ff < count_ff) ? chr_pkg::S_REM_WR : chr_pkg::S_ACK;
         chr_pkg::S_REM_WR: state_in = chr_pkg::S_REM_RD;
         chr_pkg::S_LK_RD:
            state_in = (walk_ff < count_ff && found_ff < want_ff) ? chr_pkg::S_LK_CHK
                                                                 : chr_pkg::S_EMIT;
         chr_pkg::S_LK_CHK: begin
            if (chk_ff < found_ff && seen_ff[chk_ff[RW-1:0]] == rd_own_ff)
               state_in = chr_pkg::S_LK_RD;
            else if (chk_ff < found_ff) state_in = chr_pkg::S_LK_CHK;
            else state_in = chr_pkg::S_LK_RD;
         end
         chr_pkg::S_EMIT: begin
            if ((!rsp_valid_ff || !rsp_stall) && emit_last) state_in = chr_pkg::S_IDLE;
         end
         chr_pkg::S_ACK:
            if (!rsp_valid_ff || !rsp_stall) state_in = chr_pkg::S_IDLE;
         default: state_in = chr_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      count_in = count_ff;  lo_in = lo_ff;  hi_in = hi_ff;  ptr_in = ptr_ff;
      wp_in = wp_ff;  walk_in = walk_ff;  found_in = found_ff;  want_in = want_ff;
      chk_in = chk_ff;  op_in = op_ff;  node_in = node_ff;  key_in = key_ff;
      mem_we = 1'b0;  mem_wa = ptr_ff[AW-1:0];  mem_wt = rd_tok_ff;  mem_wo = rd_own_ff;
      mem_ra = mid[AW-1:0];  seen_we = 1'b0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in = rsp_ff;
      // hold requests while one is in flight and until its last result beat has left
      req_stall = (state_ff != chr_pkg::S_IDLE) || rsp_valid_ff;
      unique case (state_ff)
         chr_pkg::S_IDLE: begin
            op_in = req_data.req_type;  node_in = req_data.node_id[NODE_ID_BITS-1:0];
            key_in = req_data.ring_token;  want_in = want_sat;
            lo_in = '0;  hi_in = count_ff;  ptr_in = '0;  wp_in = '0;
            walk_in = '0;  found_in = '0;
            mem_ra = '0;
         end
         chr_pkg::S_SRCH_RD: begin
            mem_ra = (lo_ff < hi_ff) ? mid[AW-1:0] : lo_ff[AW-1:0];
            if (!(lo_ff < hi_ff)) begin
               ptr_in = (op_ff == chr_pkg::REQ_ADD) ? count_ff
                      : ((lo_ff >= count_ff) ? '0 : lo_ff);
            end
         end
         chr_pkg::S_SRCH_CMP: begin
            if (rd_tok_ff < key_ff) lo_in = mid + 1'b1;
            else hi_in = mid;
         end
         chr_pkg::S_ADD_DEC: begin
            if (lo_ff < count_ff && rd_tok_ff == key_ff) begin
               mem_we = 1'b1;  mem_wa = lo_ff[AW-1:0];  mem_wt = key_ff;  mem_wo = node_ff;
               rsp_in = '{found_node: 8'd0, status: chr_pkg::ST_OK, last_result: 1'b1};
            end else if (count_ff >= CW'(TABLE_DEPTH)) begin
               rsp_in = '{found_node: 8'd0, status: chr_pkg::ST_FULL, last_result: 1'b1};
            end else begin
               rsp_in = '{found_node: 8'd0, status: chr_pkg::ST_OK, last_result: 1'b1};
            end
            mem_ra = AW'(ptr_ff - 1'b1);
         end
         chr_pkg::S_SHIFT_RD: mem_ra = AW'(ptr_ff - 1'b1);
         chr_pkg::S_SHIFT_WR: begin
            mem_we = 1'b1;
            if (ptr_ff > lo_ff) begin
               ptr_in = ptr_ff - 1'b1;
            end else begin
               mem_wt = key_ff;  mem_wo = node_ff;  count_in = count_ff + 1'b1;
            end
            mem_ra = AW'(ptr_ff - 2'd2);
         end
         chr_pkg::S_REM_RD: begin
            mem_ra = ptr_ff[AW-1:0];
            if (!(ptr_ff < count_ff)) begin
               count_in = wp_ff;
               rsp_in = '{found_node: 8'd0, status: chr_pkg::ST_OK, last_result: 1'b1};
            end
         end
         chr_pkg::S_REM_WR: begin
            ptr_in = ptr_ff + 1'b1;
            mem_ra = AW'(ptr_ff + 1'b1);
            if (rd_own_ff != node_ff) begin
               mem_we = 1'b1;  mem_wa = wp_ff[AW-1:0];  wp_in = wp_ff + 1'b1;
            end
         end
         chr_pkg::S_LK_RD: begin
            mem_ra = walk_idx[AW-1:0];
            chk_in = '0;
            walk_in = walk_ff;
         end
         chr_pkg::S_LK_CHK: begin
            // keep the walked entry on the read port while the seen list is compared
            mem_ra = walk_idx[AW-1:0];
            if (chk_ff < found_ff && seen_ff[chk_ff[RW-1:0]] == rd_own_ff) begin
               walk_in = walk_ff + 1'b1;
            end else if (chk_ff < found_ff) begin
               chk_in = chk_ff + 1'b1;
            end else begin
               seen_we = 1'b1;  found_in = found_ff + 1'b1;  walk_in = walk_ff + 1'b1;
            end
         end
         chr_pkg::S_EMIT: begin
            // stream the seen list once the walk is done, so the last beat is known
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               chk_in = chk_ff + 1'b1;
               rsp_in = '{found_node: 8'(seen_ff[chk_ff[RW-1:0]]), status: chr_pkg::ST_OK,
                          last_result: emit_last};
            end
         end
         chr_pkg::S_ACK: begin
            if (op_ff == chr_pkg::REQ_LOOKUP)
               rsp_in = '{found_node: 8'd0, status: chr_pkg::ST_EMPTY, last_result: 1'b1};
            if (!rsp_valid_ff || !rsp_stall) rsp_valid_in = 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= chr_pkg::S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      lo_ff <= lo_in;  hi_ff <= hi_in;  ptr_ff <= ptr_in;  wp_ff <= wp_in;
      walk_ff <= walk_in;  found_ff <= found_in;  want_ff <= want_in;  chk_ff <= chk_in;
      op_ff <= op_in;  node_ff <= node_in;  key_ff <= key_in;  rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

@@ hdl/chr_checker.sv @@
module chr_port_checker (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_stall,
   input logic                  rsp_valid,
   input logic                  rsp_stall,
   input chr_pkg::rsp_beat_type rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response beat changed");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.status != chr_pkg::ST_RSVD)
      else $error("reserved status code");

   a_ack_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != chr_pkg::ST_OK |-> rsp_data.found_node == 8'd0
                                                        && rsp_data.last_result)
      else $error("error beat carries node or is not last");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall || !rsp_valid || rsp_data.last_result)
      else $error("request accepted twice without result");

endmodule

bind consistent_hash_ring chr_port_checker u_chr_port_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
   .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
);

@@ dv/chr_checker.sv @@
module chr_checker (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_stall,
   input  chr_pkg::req_beat_type req_data,
   input  logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  chr_pkg::rsp_beat_type rsp_data,
   output int                    fail_count,
   output int                    pending_count
);

   localparam int DEPTH    = 256;
   localparam int REPLICAS = 8;
   localparam int SLOTS    = 16;

   logic [31:0]           ring_tokens [DEPTH];
   logic [7:0]            ring_owners [DEPTH];
   int                    ring_size;
   chr_pkg::rsp_beat_type expected_rsps [SLOTS];
   int                    wr_idx;
   int                    rd_idx;

   assign pending_count = wr_idx - rd_idx;

   function automatic int search_slot(logic [31:0] key);
      int lo;
      int hi;
      int mid;
      lo = 0;
      hi = ring_size;
      while (lo < hi) begin
         mid = (lo + hi) / 2;
         if (ring_tokens[mid] < key) lo = mid + 1;
         else hi = mid;
      end
      return lo;
   endfunction

   function automatic void push_rsp(logic [7:0] node, chr_pkg::status_code_type st,
                                    logic last);
      chr_pkg::rsp_beat_type r;
      r.found_node  = node;
      r.status      = st;
      r.last_result = last;
      expected_rsps[wr_idx % SLOTS] = r;
      wr_idx++;
   endfunction

   task automatic predict_ring(chr_pkg::req_beat_type b);
      int pos;
      int w;
      int want;
      int found;
      int idx;
      bit dup;
      logic [7:0] seen [REPLICAS];
      case (chr_pkg::req_code_type'(b.req_type))
         chr_pkg::REQ_ADD: begin
            pos = search_slot(b.ring_token);
            if (pos < ring_size && ring_tokens[pos] == b.ring_token) begin
               ring_owners[pos] = b.node_id;
               push_rsp(8'd0, chr_pkg::ST_OK, 1'b1);
            end else if (ring_size >= DEPTH) begin
               push_rsp(8'd0, chr_pkg::ST_FULL, 1'b1);
            end else begin
               for (int i = ring_size; i > pos; i--) begin
                  ring_tokens[i] = ring_tokens[i-1];
                  ring_owners[i] = ring_owners[i-1];
               end
               ring_tokens[pos] = b.ring_token;
               ring_owners[pos] = b.node_id;
               ring_size++;
               push_rsp(8'd0, chr_pkg::ST_OK, 1'b1);
            end
         end
         chr_pkg::REQ_REMOVE: begin
            w = 0;
            for (int r = 0; r < ring_size; r++) begin
               if (ring_owners[r] != b.node_id) begin
                  ring_tokens[w] = ring_tokens[r];
                  ring_owners[w] = ring_owners[r];
                  w++;
               end
            end
            ring_size = w;
            push_rsp(8'd0, chr_pkg::ST_OK, 1'b1);
         end
         chr_pkg::REQ_LOOKUP: begin
            if (ring_size == 0) begin
               push_rsp(8'd0, chr_pkg::ST_EMPTY, 1'b1);
            end else begin
               want = b.want_count;
               if (want == 0 || want > REPLICAS) want = REPLICAS;
               pos = search_slot(b.ring_token);
               if (pos >= ring_size) pos = 0;
               found = 0;
               for (int i = 0; i < ring_size && found < want; i++) begin
                  idx = (pos + i) % ring_size;
                  dup = 0;
                  for (int j = 0; j < found; j++)
                     if (seen[j] == ring_owners[idx]) dup = 1;
                  if (!dup) begin
                     seen[found] = ring_owners[idx];
                     found++;
                  end
               end
               for (int j = 0; j < found; j++)
                  push_rsp(seen[j], chr_pkg::ST_OK, j == found - 1);
            end
         end
         default: ;
      endcase
   endtask

   always @(posedge clock) begin
      chr_pkg::rsp_beat_type want_rsp;
      if (reset) begin
         ring_size  = 0;
         fail_count = 0;
         wr_idx     = 0;
         rd_idx     = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (wr_idx == rd_idx) begin
               $display("%0t: unexpected beat, expected none, actual %p", $time, rsp_data);
               fail_count++;
            end else begin
               want_rsp = expected_rsps[rd_idx % SLOTS];
               rd_idx++;
               if (want_rsp !== rsp_data) begin
                  $display("%0t: mismatch, expected %p, actual %p", $time, want_rsp,
                           rsp_data);
                  fail_count++;
               end
            end
         end
         if (req_valid && !req_stall) predict_ring(req_data);
      end
   end

endmodule

@@ dv/tb.sv @@
module tb;

   logic                  clock = 0;
   logic                  reset = 1;
   logic                  req_valid = 0;
   logic                  req_stall;
   chr_pkg::req_beat_type req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 0;
   chr_pkg::rsp_beat_type rsp_data;
   int                    fail_count;
   int                    pending_count;

   always #1 clock = ~clock;

   consistent_hash_ring uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   chr_checker chk (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .fail_count(fail_count), .pending_count(pending_count)
   );

   function automatic int gap_len();
      if ($urandom_range(0, 19) == 0) return $urandom_range(10, 60);
      if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
      return 0;
   endfunction

   // small token space on most adds so overwrites and lookups hit real entries
   function automatic logic [31:0] pick_token();
      case ($urandom_range(0, 3))
         0: return $urandom_range(0, 63) << 26;
         1: return 32'hFFFF_FFC0 | $urandom_range(0, 63);
         2: return $urandom_range(0, 63);
         default: return $urandom();
      endcase
   endfunction

   // drop valid only for a gap, so back-to-back beats keep it high
   task automatic send(chr_pkg::req_code_type t, logic [7:0] n, logic [31:0] tok,
                       logic [3:0] cnt);
      int gap;
      gap = gap_len();
      @(negedge clock);
      if (gap != 0) begin
         req_valid <= 0;
         repeat (gap) @(negedge clock);
      end
      req_data  <= {t, n, tok, cnt};
      req_valid <= 1;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic send_random();
      int r;
      r = $urandom_range(0, 99);
      if (r < 45)
         send(chr_pkg::REQ_ADD, 8'($urandom_range(0, 15)), pick_token(), 4'($urandom()));
      else if (r < 55)
         send(chr_pkg::REQ_REMOVE, 8'($urandom_range(0, 17)), $urandom(), 4'($urandom()));
      else if (r < 97)
         send(chr_pkg::REQ_LOOKUP, 8'($urandom()), pick_token(), 4'($urandom()));
      else
         send(chr_pkg::REQ_NONE, 8'($urandom()), $urandom(), 4'($urandom()));
   endtask

   // receiver stall pattern, with long quiet stretches
   initial begin
      forever begin
         @(negedge clock);
         if ($urandom_range(0, 299) == 0) repeat (400) @(negedge clock);
         if ($urandom_range(0, 30) == 0) begin
            rsp_stall <= 1;
            repeat ($urandom_range(10, 50)) @(negedge clock);
         end else begin
            rsp_stall <= ($urandom_range(0, 3) == 0);
         end
      end
   end

   initial begin
      int guard;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      send(chr_pkg::REQ_LOOKUP, 8'h00, 32'h0, 4'd3);
      send(chr_pkg::REQ_REMOVE, 8'h05, 32'h0, 4'd0);
      send(chr_pkg::REQ_ADD, 8'hFF, 32'hFFFF_FFFF, 4'hF);
      send(chr_pkg::REQ_ADD, 8'h00, 32'h0000_0000, 4'd0);
      send(chr_pkg::REQ_ADD, 8'hAA, 32'h8000_0000, 4'd1);
      send(chr_pkg::REQ_ADD, 8'h55, 32'h8000_0000, 4'd1);
      send(chr_pkg::REQ_ADD, 8'h55, 32'h4000_0000, 4'd1);
      send(chr_pkg::REQ_LOOKUP, 8'h00, 32'h8000_0001, 4'd1);
      send(chr_pkg::REQ_LOOKUP, 8'hFF, 32'hFFFF_FFFF, 4'd0);
      send(chr_pkg::REQ_LOOKUP, 8'h00, 32'h0000_0001, 4'd15);
      send(chr_pkg::REQ_LOOKUP, 8'h00, 32'h0000_0000, 4'd8);
      send(chr_pkg::REQ_NONE, 8'hFF, 32'hFFFF_FFFF, 4'hF);
      send(chr_pkg::REQ_REMOVE, 8'h55, 32'h0, 4'd0);
      send(chr_pkg::REQ_LOOKUP, 8'h00, 32'h4000_0000, 4'd2);
      // fill the table to capacity, then hit it with a new token and an overwrite
      for (int i = 0; i < 256; i++)
         send(chr_pkg::REQ_ADD, i[7:0], 32'h0100_0000 + i * 32'h0001_0001, 4'd0);
      send(chr_pkg::REQ_ADD, 8'h11, 32'h7777_7777, 4'd0);
      send(chr_pkg::REQ_ADD, 8'h22, 32'h0100_0000, 4'd0);
      send(chr_pkg::REQ_LOOKUP, 8'h00, 32'h0100_0000, 4'd8);
      // free the entries of nodes 0 to 63 so random adds can insert again
      for (int i = 0; i < 64; i++) send(chr_pkg::REQ_REMOVE, i[7:0], 32'h0, 4'd0);
      for (int i = 0; i < 80; i++) send_random();
      @(negedge clock);
      req_valid <= 0;
      guard = 0;
      while (pending_count != 0 && guard < 200000) begin
         @(posedge clock);
         guard++;
      end
      repeat (2000) @(posedge clock);
      if (fail_count == 0 && pending_count == 0)
         $display("consistent_hash_ring regression: pass");
      else
         $display("consistent_hash_ring regression: fail");
      $finish;
   end

   initial begin
      #3000000;
      $display("consistent_hash_ring regression: fail");
      $finish;
   end

endmodule
